// ===== design/aarm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// aarm_pkg
// Shared types and constants for the axis-angle rotation matrix block.
// ----------------------------------------------------------------------------
package aarm_pkg;

   localparam int NUM_REGS = 6;

   typedef enum logic [2:0] {
      REG_UP_X  = 3'd0,
      REG_UP_Y  = 3'd1,
      REG_UP_Z  = 3'd2,
      REG_FWD_X = 3'd3,
      REG_FWD_Y = 3'd4,
      REG_FWD_Z = 3'd5
   } reg_index_type;

   typedef enum logic [1:0] {
      AXIS_RIGHT   = 2'd0,
      AXIS_UP      = 2'd1,
      AXIS_FORWARD = 2'd2,
      AXIS_NONE    = 2'd3
   } axis_type;

   localparam logic signed [31:0] Q30_GAIN = 32'sd652032874;
   localparam logic signed [35:0] PI_OVER_18000_Q46 = 36'sd12281662764;

   function automatic logic signed [31:0] atan_q30(input int i);
      logic signed [31:0] v;
      case (i)
         0: v = 32'sd843314856;   1: v = 32'sd497837829;
         2: v = 32'sd263043836;   3: v = 32'sd133525158;
         4: v = 32'sd67021686;    5: v = 32'sd33543515;
         6: v = 32'sd16775850;    7: v = 32'sd8388437;
         8: v = 32'sd4194282;     9: v = 32'sd2097149;
         10: v = 32'sd1048575;    11: v = 32'sd524287;
         12: v = 32'sd262143;     13: v = 32'sd131071;
         14: v = 32'sd65535;      15: v = 32'sd32767;
         16: v = 32'sd16383;      17: v = 32'sd8191;
         18: v = 32'sd4095;       19: v = 32'sd2047;
         20: v = 32'sd1023;       21: v = 32'sd511;
         22: v = 32'sd255;        23: v = 32'sd127;
         24: v = 32'sd63;         25: v = 32'sd31;
         26: v = 32'sd15;         27: v = 32'sd7;
         28: v = 32'sd3;          29: v = 32'sd1;
         default: v = 32'sd0;
      endcase
      return v;
   endfunction

endpackage
`default_nettype wire

// ===== design/axis_angle_rotation_matrix.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// axis_angle_rotation_matrix
// Rotation matrix about one of the object's axes (right, up, forward).
// ----------------------------------------------------------------------------
// Input channel req_*: axis code and angle in hundredths of a degree.
// Result channel rsp_*: nine Q2.14 matrix entries and a saturation flag.
// csr_*: write-only port for the up and forward axis registers.
// A request passes two angle stages with the axis stage beside the first,
// one CORDIC stage per micro-rotation, three matrix stages and one output
// register on its way to the response. One transfer per cycle is accepted
// sustained; the whole pipeline advances together and holds when the
// output register is full and the receiver stalls, so nothing is dropped
// or repeated.
// Reset clears all valid bits and loads up = (0, 1.0, 0), fwd = (0, 0, 1.0).
// The right axis is up x forward, computed on each transfer from the
// registers in the cycle it enters.
// ----------------------------------------------------------------------------
module axis_angle_rotation_matrix #(
   parameter int FRAC_BITS    = 14,
   parameter int CORDIC_ITERS = 16
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_ready,
   input  wire logic [1:0]          req_axis_select,
   input  wire logic signed [16:0]  req_angle_centideg,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output logic signed [15:0]       rsp_m_r0c0,
   output logic signed [15:0]       rsp_m_r0c1,
   output logic signed [15:0]       rsp_m_r0c2,
   output logic signed [15:0]       rsp_m_r1c0,
   output logic signed [15:0]       rsp_m_r1c1,
   output logic signed [15:0]       rsp_m_r1c2,
   output logic signed [15:0]       rsp_m_r2c0,
   output logic signed [15:0]       rsp_m_r2c1,
   output logic signed [15:0]       rsp_m_r2c2,
   output logic                     rsp_saturated,
   input  wire logic                csr_write,
   input  wire logic [2:0]          csr_index,
   input  wire logic [15:0]         csr_data
);
   import aarm_pkg::*;

   localparam int N     = (CORDIC_ITERS > 32) ? 32 : CORDIC_ITERS;
   localparam int DEPTH = N + 5;   // internal stages before the output register

   // configuration registers
   logic signed [15:0] cfg_ff [NUM_REGS];
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff[REG_UP_X]  <= '0;
         cfg_ff[REG_UP_Y]  <= 16'sh4000;
         cfg_ff[REG_UP_Z]  <= '0;
         cfg_ff[REG_FWD_X] <= '0;
         cfg_ff[REG_FWD_Y] <= '0;
         cfg_ff[REG_FWD_Z] <= 16'sh4000;
      end else if (csr_write && csr_index < 3'(NUM_REGS)) begin
         cfg_ff[csr_index] <= csr_data;
      end
   end

   // advance the whole pipeline unless the output register holds a stalled result
   logic advance;
   logic out_valid_ff;
   assign advance   = !out_valid_ff || rsp_ready;
   assign req_ready = advance;

   logic [DEPTH-1:0] vld_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (advance) begin
         vld_ff <= {vld_ff[DEPTH-2:0], req_valid};
      end
   end

   // axis selection: register the chosen axis (right = rounded up x forward) and the identity flag
   logic signed [32:0] cr [3];
   logic signed [17:0] n_in [3];
   logic signed [17:0] n1_ff [3];
   logic               id1_ff;
   always_comb begin
      cr[0] = 33'(cfg_ff[REG_UP_Y]) * 33'(cfg_ff[REG_FWD_Z])
            - 33'(cfg_ff[REG_UP_Z]) * 33'(cfg_ff[REG_FWD_Y]);
      cr[1] = 33'(cfg_ff[REG_UP_Z]) * 33'(cfg_ff[REG_FWD_X])
            - 33'(cfg_ff[REG_UP_X]) * 33'(cfg_ff[REG_FWD_Z]);
      cr[2] = 33'(cfg_ff[REG_UP_X]) * 33'(cfg_ff[REG_FWD_Y])
            - 33'(cfg_ff[REG_UP_Y]) * 33'(cfg_ff[REG_FWD_X]);
      for (int i = 0; i < 3; i++) begin
         case (axis_type'(req_axis_select))
            AXIS_RIGHT:   n_in[i] = 18'((cr[i] + (33'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS);
            AXIS_UP:      n_in[i] = 18'(cfg_ff[i]);
            AXIS_FORWARD: n_in[i] = 18'(cfg_ff[3 + i]);
            default:      n_in[i] = '0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         n1_ff  <= n_in;
         id1_ff <= (axis_type'(req_axis_select) == AXIS_NONE);
      end
   end

   // two angle stages; delay axis data to match
   logic signed [31:0] theta;
   logic               neg;
   logic signed [17:0] n2_ff [3];
   logic               id2_ff;
   aarm_angle u_angle (
      .clock     (clock),
      .advance   (advance),
      .angle_in  (req_angle_centideg),
      .theta_q30 (theta),
      .negate    (neg)
   );
   always_ff @(posedge clock) begin
      if (advance) begin
         n2_ff  <= n1_ff;
         id2_ff <= id1_ff;
      end
   end

   // side data: axis (3 x 18 bits), identity flag, fold sign
   localparam int SW = 56;
   logic [SW-1:0] side_in, side_out;
   assign side_in = {n2_ff[0], n2_ff[1], n2_ff[2], id2_ff, neg};

   logic signed [33:0] cx, cy;
   aarm_cordic #(.ITERS(CORDIC_ITERS), .SIDE_W(SW)) u_cordic (
      .clock    (clock),
      .advance  (advance),
      .theta    (theta),
      .side_in  (side_in),
      .x_out    (cx),
      .y_out    (cy),
      .side_out (side_out)
   );

   logic signed [17:0] nc [3];
   assign nc[0] = side_out[55:38];
   assign nc[1] = side_out[37:20];
   assign nc[2] = side_out[19:2];

   logic signed [15:0] m [9];
   logic               sat;
   aarm_matrix #(.FRAC_BITS(FRAC_BITS)) u_matrix (
      .clock    (clock),
      .advance  (advance),
      .ident_in (side_out[1]),
      .x_in     (cx),
      .y_in     (cy),
      .negate   (side_out[0]),
      .n_in     (nc),
      .m_out    (m),
      .sat_out  (sat)
   );

   // output register
   logic signed [15:0] out_ff [9];
   logic               out_sat_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= vld_ff[DEPTH-1];
      end
   end
   always_ff @(posedge clock) begin
      if (advance) begin
         out_ff     <= m;
         out_sat_ff <= sat;
      end
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_m_r0c0    = out_ff[0];
   assign rsp_m_r0c1    = out_ff[1];
   assign rsp_m_r0c2    = out_ff[2];
   assign rsp_m_r1c0    = out_ff[3];
   assign rsp_m_r1c1    = out_ff[4];
   assign rsp_m_r1c2    = out_ff[5];
   assign rsp_m_r2c0    = out_ff[6];
   assign rsp_m_r2c1    = out_ff[7];
   assign rsp_m_r2c2    = out_ff[8];
   assign rsp_saturated = out_sat_ff;
endmodule
`default_nettype wire

// ===== design/aarm_angle.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// aarm_angle
// Angle reduction stage: wrap to one turn, fold to +-90 degrees, scale to Q30.
// Two register stages, gated by a common advance enable.
// ----------------------------------------------------------------------------
module aarm_angle (
   input  wire logic                clock,
   input  wire logic                advance,
   input  wire logic signed [16:0]  angle_in,
   output logic signed [31:0]       theta_q30,
   output logic                     negate
);
   import aarm_pkg::*;

   // 17-bit signed angle lies in [-65536, 65535]; a few corrections wrap it.
   logic signed [18:0] r0, r1;
   logic signed [17:0] red_ff, red_in;
   logic               neg_ff, neg_in;
   logic signed [51:0] prod;
   logic signed [31:0] theta_ff;
   logic               neg2_ff;

   always_comb begin
      r0 = 19'(angle_in);
      if (r0 >= 19'sd36000)
         r0 = r0 - 19'sd36000;
      if (r0 >= 19'sd36000)
         r0 = r0 - 19'sd36000;
      if (r0 < 19'sd0)
         r0 = r0 + 19'sd36000;
      if (r0 < 19'sd0)
         r0 = r0 + 19'sd36000;
      neg_in = 1'b0;
      if (r0 <= 19'sd9000) begin
         r1 = r0;
      end else if (r0 <= 19'sd27000) begin
         r1 = r0 - 19'sd18000;
         neg_in = 1'b1;
      end else begin
         r1 = r0 - 19'sd36000;
      end
      red_in = 18'(r1);
   end

   assign prod = 52'(red_ff) * 52'(PI_OVER_18000_Q46) + 52'sd32768;

   always_ff @(posedge clock) begin
      if (advance) begin
         red_ff   <= red_in;
         neg_ff   <= neg_in;
         theta_ff <= 32'(prod >>> 16);
         neg2_ff  <= neg_ff;
      end
   end

   assign theta_q30 = theta_ff;
   assign negate    = neg2_ff;
endmodule
`default_nettype wire

// ===== design/aarm_cordic.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// aarm_cordic
// Pipelined CORDIC rotation, one micro-rotation per stage, Q30.
// Side data travels along with each stage.
// ----------------------------------------------------------------------------
module aarm_cordic #(
   parameter int ITERS = 16,
   parameter int SIDE_W = 8
) (
   input  wire logic                clock,
   input  wire logic                advance,
   input  wire logic signed [31:0]  theta,
   input  wire logic [SIDE_W-1:0]   side_in,
   output logic signed [33:0]       x_out,
   output logic signed [33:0]       y_out,
   output logic [SIDE_W-1:0]        side_out
);
   import aarm_pkg::*;

   localparam int N = (ITERS > 32) ? 32 : ITERS;

   logic signed [33:0] x_ff [N+1];
   logic signed [33:0] y_ff [N+1];
   logic signed [33:0] z_ff [N+1];
   logic [SIDE_W-1:0]  s_ff [N+1];

   always_comb begin
      x_ff[0] = 34'(Q30_GAIN);
      y_ff[0] = 34'sd0;
      z_ff[0] = 34'(theta);
      s_ff[0] = side_in;
   end

   for (genvar i = 0; i < N; i++) begin : g_stage
      logic signed [33:0] x_in, y_in, z_in;
      always_comb begin
         if (z_ff[i] >= 34'sd0) begin
            x_in = x_ff[i] - (y_ff[i] >>> i);
            y_in = y_ff[i] + (x_ff[i] >>> i);
            z_in = z_ff[i] - 34'(atan_q30(i));
         end else begin
            x_in = x_ff[i] + (y_ff[i] >>> i);
            y_in = y_ff[i] - (x_ff[i] >>> i);
            z_in = z_ff[i] + 34'(atan_q30(i));
         end
      end
      always_ff @(posedge clock) begin
         if (advance) begin
            x_ff[i+1] <= x_in;
            y_ff[i+1] <= y_in;
            z_ff[i+1] <= z_in;
            s_ff[i+1] <= s_ff[i];
         end
      end
   end

   assign x_out    = x_ff[N];
   assign y_out    = y_ff[N];
   assign side_out = s_ff[N];
   // final angle residue is not needed
   logic unused_z;
   assign unused_z = ^z_ff[N];
endmodule
`default_nettype wire

// ===== design/aarm_matrix.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// aarm_matrix
// Matrix assembly: products, rounding, sums and saturation over three
// register stages.
// ----------------------------------------------------------------------------
module aarm_matrix #(
   parameter int FRAC_BITS = 14
) (
   input  wire logic                clock,
   input  wire logic                advance,
   input  wire logic                ident_in,
   input  wire logic signed [33:0]  x_in,
   input  wire logic signed [33:0]  y_in,
   input  wire logic                negate,
   input  wire logic signed [17:0]  n_in [3],
   output logic signed [15:0]       m_out [9],
   output logic                     sat_out
);
   import aarm_pkg::*;

   localparam int F  = FRAC_BITS;
   localparam int CS = 30 - F;
   localparam logic signed [35:0] ONE = 36'sd1 <<< F;

   // stage A: sign repair, round to F bits, 1-c, n products
   logic signed [33:0] xn, yn;
   logic signed [34:0] cr, sr;
   logic signed [35:0] c_ff, s_ff, omc_ff;
   logic signed [36:0] nn_ff [6];   // xx yy zz xy xz yz
   logic signed [17:0] na_ff [3];
   logic               ida_ff;

   always_comb begin
      xn = negate ? -x_in : x_in;
      yn = negate ? -y_in : y_in;
      if (CS == 0) begin
         cr = 35'(xn);
         sr = 35'(yn);
      end else begin
         cr = (35'(xn) + (35'sd1 <<< (CS > 0 ? CS - 1 : 0))) >>> CS;
         sr = (35'(yn) + (35'sd1 <<< (CS > 0 ? CS - 1 : 0))) >>> CS;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         c_ff     <= 36'(cr);
         s_ff     <= 36'(sr);
         omc_ff   <= ONE - 36'(cr);
         nn_ff[0] <= 37'(n_in[0]) * 37'(n_in[0]);
         nn_ff[1] <= 37'(n_in[1]) * 37'(n_in[1]);
         nn_ff[2] <= 37'(n_in[2]) * 37'(n_in[2]);
         nn_ff[3] <= 37'(n_in[0]) * 37'(n_in[1]);
         nn_ff[4] <= 37'(n_in[0]) * 37'(n_in[2]);
         nn_ff[5] <= 37'(n_in[1]) * 37'(n_in[2]);
         na_ff    <= n_in;
         ida_ff   <= ident_in;
      end
   end

   // stage B: (1-c)*nn and s*n, rounded
   localparam int PW = 74;
   logic signed [PW-1:0] p [6];
   logic signed [55:0]   q [3];
   logic signed [47:0]   t_ff [6];
   logic signed [39:0]   st_ff [3];
   logic signed [35:0]   cb_ff;
   logic                 idb_ff;

   always_comb begin
      for (int i = 0; i < 6; i++)
         p[i] = (PW'(omc_ff) * PW'(nn_ff[i]) + (PW'(1) <<< (2*F - 1))) >>> (2*F);
      for (int i = 0; i < 3; i++)
         q[i] = (56'(s_ff) * 56'(na_ff[i]) + (56'sd1 <<< (F - 1))) >>> F;
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int i = 0; i < 6; i++)
            t_ff[i] <= 48'(p[i]);
         for (int i = 0; i < 3; i++)
            st_ff[i] <= 40'(q[i]);
         cb_ff  <= c_ff;
         idb_ff <= ida_ff;
      end
   end

   // stage C: sums, identity override and saturation
   logic signed [49:0] v [9];
   logic signed [15:0] m_in [9];
   logic               sat_in;
   logic signed [15:0] m_ff [9];
   logic               sat_ff;

   always_comb begin
      v[0] = 50'(t_ff[0]) + 50'(cb_ff);
      v[4] = 50'(t_ff[1]) + 50'(cb_ff);
      v[8] = 50'(t_ff[2]) + 50'(cb_ff);
      v[1] = 50'(t_ff[3]) + 50'(st_ff[2]);
      v[3] = 50'(t_ff[3]) - 50'(st_ff[2]);
      v[2] = 50'(t_ff[4]) - 50'(st_ff[1]);
      v[6] = 50'(t_ff[4]) + 50'(st_ff[1]);
      v[5] = 50'(t_ff[5]) + 50'(st_ff[0]);
      v[7] = 50'(t_ff[5]) - 50'(st_ff[0]);
      if (idb_ff) begin
         for (int i = 0; i < 9; i++)
            v[i] = (i % 4 == 0) ? 50'(ONE) : 50'sd0;
      end
      sat_in = 1'b0;
      for (int i = 0; i < 9; i++) begin
         if (v[i] > 50'sd32767) begin
            m_in[i] = 16'sh7fff;
            sat_in  = 1'b1;
         end else if (v[i] < -50'sd32768) begin
            m_in[i] = 16'sh8000;
            sat_in  = 1'b1;
         end else begin
            m_in[i] = 16'(v[i]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         m_ff   <= m_in;
         sat_ff <= sat_in;
      end
   end

   assign m_out   = m_ff;
   assign sat_out = sat_ff;
endmodule
`default_nettype wire

// ===== sim/tb_axis_angle_rotation_matrix.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_axis_angle_rotation_matrix
// Self-checking bench for the axis-angle rotation matrix block.
// ----------------------------------------------------------------------------
// A behavioral predictor computes each rotation matrix from the axis
// registers and the request, and every response is compared entry by entry
// with the oldest prediction. Directed tests cover angle extremes, every axis
// code and register extremes; random tests cover the rest with random gaps
// on both channels.
// ----------------------------------------------------------------------------
module tb_axis_angle_rotation_matrix;
   import aarm_pkg::*;

   localparam int FRAC = 14;
   localparam int ITERS = 16;
   localparam int LATENCY = ITERS + 6;
   localparam longint CYCLE_LIMIT = 400000;

   typedef struct packed {
      logic signed [15:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;
      logic               sat;
   } matrix_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [1:0] req_axis_select = '0;
   logic signed [16:0] req_angle_centideg = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic signed [15:0] rsp_m_r0c0, rsp_m_r0c1, rsp_m_r0c2, rsp_m_r1c0, rsp_m_r1c1;
   logic signed [15:0] rsp_m_r1c2, rsp_m_r2c0, rsp_m_r2c1, rsp_m_r2c2;
   logic rsp_saturated;
   logic csr_write = 1'b0;
   logic [2:0] csr_index = '0;
   logic [15:0] csr_data = '0;

   logic signed [15:0] axis_regs [0:7];
   matrix_type expected_matrices [$];
   int mismatch_count = 0;
   longint cycle_count = 0;
   bit rsp_stall_enable = 1'b1;

   axis_angle_rotation_matrix #(.FRAC_BITS(FRAC), .CORDIC_ITERS(ITERS)) u_dut (.*);

   initial begin
      forever #1 clock = ~clock;
   end

   // Abort on a hung pipeline.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   function automatic longint floor_shift(longint v, int s);
      return v >>> s;
   endfunction

   function automatic longint round_shift(longint v, int s);
      if (s == 0) return v;
      return (v + (longint'(1) << (s - 1))) >>> s;
   endfunction

   function automatic logic signed [15:0] clamp16(longint v, ref bit flag);
      if (v > 32767) begin
         flag = 1'b1;
         return 16'sh7fff;
      end
      if (v < -32768) begin
         flag = 1'b1;
         return 16'sh8000;
      end
      return 16'(v);
   endfunction

   // Fixed-point sine and cosine by CORDIC rotation, result at FRAC bits.
   task automatic cordic_sin_cos(input longint centideg, output longint s, output longint c);
      longint r, a, x, y, z, dx, dy;
      bit negate;
      r = centideg % 36000;
      negate = 1'b0;
      if (r < 0) r += 36000;
      if (r <= 9000) a = r;
      else if (r <= 27000) begin
         a = r - 18000;
         negate = 1'b1;
      end else a = r - 36000;
      z = round_shift(a * longint'(PI_OVER_18000_Q46), 16);
      x = longint'(Q30_GAIN);
      y = 0;
      for (int i = 0; i < ITERS; i++) begin
         dx = floor_shift(y, i);
         dy = floor_shift(x, i);
         if (z >= 0) begin
            x -= dx; y += dy; z -= longint'(atan_q30(i));
         end else begin
            x += dx; y -= dy; z += longint'(atan_q30(i));
         end
      end
      if (negate) begin
         x = -x; y = -y;
      end
      c = round_shift(x, 30 - FRAC);
      s = round_shift(y, 30 - FRAC);
   endtask

   task automatic predict_rotation(input axis_type axis, input logic signed [16:0] angle,
                                   output matrix_type m);
      longint up [3], fw [3], n [3], e [9];
      longint s, c, omc, st, one;
      logic signed [15:0] q [9];
      bit flag;
      int k;
      one = longint'(1) << FRAC;
      flag = 1'b0;
      for (int i = 0; i < 3; i++) begin
         up[i] = axis_regs[i];
         fw[i] = axis_regs[3 + i];
      end
      if (axis == AXIS_NONE) begin
         for (int i = 0; i < 9; i++) e[i] = (i % 4 == 0) ? one : 0;
      end else begin
         case (axis)
            AXIS_RIGHT: begin
               n[0] = round_shift(up[1] * fw[2] - up[2] * fw[1], FRAC);
               n[1] = round_shift(up[2] * fw[0] - up[0] * fw[2], FRAC);
               n[2] = round_shift(up[0] * fw[1] - up[1] * fw[0], FRAC);
            end
            AXIS_UP: n = up;
            default: n = fw;
         endcase
         cordic_sin_cos(longint'(angle), s, c);
         omc = one - c;
         for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
               e[i * 3 + j] = round_shift(omc * (n[i] * n[j]), 2 * FRAC);
               if (i == j) e[i * 3 + j] += c;
               else begin
                  k = 3 - i - j;
                  st = round_shift(s * n[k], FRAC);
                  // Skew term: plus for the cyclic successor column, minus otherwise.
                  if (j == (i + 1) % 3) e[i * 3 + j] += st;
                  else e[i * 3 + j] -= st;
               end
            end
         end
      end
      for (int i = 0; i < 9; i++) q[i] = clamp16(e[i], flag);
      m = '{q[0], q[1], q[2], q[3], q[4], q[5], q[6], q[7], q[8], flag};
   endtask

   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("mismatch %s: got %0d expected %0d", what, got, want);
      mismatch_count++;
   endtask

   // Drive the response ready and check each response transfer.
   always @(negedge clock) begin
      if (reset) rsp_ready <= 1'b0;
      else if (!rsp_stall_enable) rsp_ready <= 1'b1;
      else if ($urandom_range(0, 99) < 3) rsp_ready <= 1'b0;
      else if ($urandom_range(0, 99) < 25) rsp_ready <= 1'b0;
      else rsp_ready <= 1'b1;
   end

   always @(posedge clock) begin
      matrix_type want, got;
      if (!reset && rsp_valid && rsp_ready) begin
         got = '{rsp_m_r0c0, rsp_m_r0c1, rsp_m_r0c2, rsp_m_r1c0, rsp_m_r1c1, rsp_m_r1c2,
                 rsp_m_r2c0, rsp_m_r2c1, rsp_m_r2c2, rsp_saturated};
         if (expected_matrices.size() == 0) report_mismatch("unexpected response", 0, 0);
         else begin
            want = expected_matrices.pop_front();
            if (got.m00 !== want.m00) report_mismatch("r0c0", got.m00, want.m00);
            if (got.m01 !== want.m01) report_mismatch("r0c1", got.m01, want.m01);
            if (got.m02 !== want.m02) report_mismatch("r0c2", got.m02, want.m02);
            if (got.m10 !== want.m10) report_mismatch("r1c0", got.m10, want.m10);
            if (got.m11 !== want.m11) report_mismatch("r1c1", got.m11, want.m11);
            if (got.m12 !== want.m12) report_mismatch("r1c2", got.m12, want.m12);
            if (got.m20 !== want.m20) report_mismatch("r2c0", got.m20, want.m20);
            if (got.m21 !== want.m21) report_mismatch("r2c1", got.m21, want.m21);
            if (got.m22 !== want.m22) report_mismatch("r2c2", got.m22, want.m22);
            if (got.sat !== want.sat) report_mismatch("saturated", got.sat, want.sat);
         end
      end
   end

   // Send one request; optional random gap first. Predict on the transfer edge.
   // Valid stays up after the transfer; a gap or the idle task drops it.
   task automatic send_rotation(input axis_type axis, input logic signed [16:0] angle,
                                input bit gaps);
      matrix_type m;
      int gap;
      gap = 0;
      if (gaps) begin
         if ($urandom_range(0, 99) < 4) gap = $urandom_range(10, 60);
         else if ($urandom_range(0, 99) < 30) gap = $urandom_range(1, 3);
      end
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_axis_select <= axis;
      req_angle_centideg <= angle;
      do @(posedge clock); while (!req_ready);
      predict_rotation(axis, angle, m);
      expected_matrices.push_back(m);
      @(negedge clock);
   endtask

   task automatic drain_responses();
      req_valid <= 1'b0;
      while (expected_matrices.size() != 0) @(negedge clock);
      repeat (LATENCY + 4) @(negedge clock);
   endtask

   // Write one axis register; only call with the pipeline drained.
   task automatic write_axis_reg(input reg_index_type idx, input logic signed [15:0] value);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      @(negedge clock);
      axis_regs[idx] = value;
   endtask

   task automatic load_axes(input logic signed [15:0] ux, uy, uz, fx, fy, fz);
      drain_responses();
      write_axis_reg(REG_UP_X, ux);
      write_axis_reg(REG_UP_Y, uy);
      write_axis_reg(REG_UP_Z, uz);
      write_axis_reg(REG_FWD_X, fx);
      write_axis_reg(REG_FWD_Y, fy);
      write_axis_reg(REG_FWD_Z, fz);
      csr_write <= 1'b0;
   endtask

   task automatic random_angle(output logic signed [16:0] a);
      case ($urandom_range(0, 5))
         0: a = 17'($urandom);
         1: a = 17'(int'($urandom_range(0, 8)) * 4500 - 18000 * $urandom_range(0, 2));
         default: a = 17'(int'($urandom_range(0, 72000)) - 36000);
      endcase
   endtask

   // Angle extremes and quadrant edges on the default axes, all axis codes.
   task automatic test_directed_angles();
      int angles [12] = '{0, 9000, 9001, 18000, 27000, 27001, 35999, 36000, -36000,
                          -9000, 65535, -65536};
      foreach (angles[i]) send_rotation(axis_type'(i % 4), 17'(angles[i]), 1'b0);
      send_rotation(AXIS_NONE, 17'sd4500, 1'b0);
      send_rotation(AXIS_RIGHT, 17'sd4500, 1'b0);
   endtask

   // Register extremes: saturating axes, zero axes and long axes.
   task automatic test_register_extremes();
      load_axes(16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh8000, 16'sh8000);
      for (int i = 0; i < 4; i++) send_rotation(axis_type'(i), 17'sd13500, 1'b0);
      load_axes(16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff);
      for (int i = 0; i < 4; i++) send_rotation(axis_type'(i), -17'sd6000, 1'b0);
      load_axes('0, '0, '0, '0, '0, '0);
      send_rotation(AXIS_RIGHT, 17'sd18000, 1'b0);
      send_rotation(AXIS_UP, 17'sd9000, 1'b0);
      // Ignored index beyond the register list; axis shadow stays as it is.
      drain_responses();
      csr_write <= 1'b1;
      csr_index <= 3'd7;
      csr_data <= 16'hffff;
      @(negedge clock);
      csr_write <= 1'b0;
      send_rotation(AXIS_FORWARD, 17'sd9000, 1'b0);
   endtask

   // Random axes and angles under several register settings, random gaps.
   task automatic test_random_rotations();
      logic signed [16:0] a;
      for (int phase = 0; phase < 5; phase++) begin
         case (phase)
            0: load_axes(16'sd0, 16'sd16384, 16'sd0, 16'sd0, 16'sd0, 16'sd16384);
            1: load_axes(16'sd11585, 16'sd0, 16'sd11585, -16'sd11585, 16'sd0, 16'sd11585);
            default: load_axes(16'($urandom), 16'($urandom), 16'($urandom),
                               16'($urandom), 16'($urandom), 16'($urandom));
         endcase
         rsp_stall_enable = (phase != 2);
         for (int i = 0; i < 200; i++) begin
            random_angle(a);
            send_rotation(axis_type'($urandom_range(0, 3)), a, phase != 3);
            // Hold off until the pipeline has emptied, once per phase.
            if (i == 100) begin
               req_valid <= 1'b0;
               while (expected_matrices.size() != 0) @(negedge clock);
            end
         end
      end
      rsp_stall_enable = 1'b1;
   endtask

   initial begin
      for (int i = 0; i < 8; i++) axis_regs[i] = '0;
      axis_regs[REG_UP_Y] = 16'sd16384;
      axis_regs[REG_FWD_Z] = 16'sd16384;
      repeat (11) @(negedge clock);
      reset <= 1'b0;
      test_directed_angles();
      test_register_extremes();
      test_random_rotations();
      drain_responses();
      if (mismatch_count == 0 && expected_matrices.size() == 0) $display("tb: success");
      else $display("tb: failure");
      $finish;
   end

endmodule
